// ===== hw/rtl/mts_pkg.sv =====
package mts_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Request opcodes. The unused code behaves as a query.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // Error codes reported with every result.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ERR_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic signed [DATA_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic signed [DATA_WIDTH-1:0] min_value;
        logic                         is_empty;
        logic                         is_full;
        logic [1:0]                   error_code;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== hw/rtl/mts_req_if.sv =====
// Request channel of the stack.
interface mts_req_if;
    logic          valid;
    logic          ready;
    mts_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mts_rsp_if.sv =====
// Result channel of the stack.
interface mts_rsp_if;
    logic          valid;
    logic          ready;
    mts_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/min_tracking_stack.sv =====
// LIFO stack of signed values that also reports the minimum of what it holds.
// Each request pushes a value, pops the top or queries, and yields exactly one
// result with the popped value (or the current top), the minimum, the empty and
// full flags and an error code; a pop on an empty stack or a push on a full one
// is reported and leaves the stack unchanged. A request is handled in an accept
// step, in which the data and minimum memories are read at the top of stack,
// and an execute step that uses the registered read data, writes back and
// loads the result register. No new request is accepted until the execute
// step of the last one is done. A finished result waits in an output register,
// and the next request is accepted while it waits; the execute step stalls
// only if the previous result has still not been taken. No clearing pass is
// needed after reset.
module min_tracking_stack (
    input  logic       clk,
    input  logic       rst_n,
    mts_req_if.sink    req,
    mts_rsp_if.source  rsp
);

    localparam int AW = mts_pkg::ADDR_W;
    localparam int CW = mts_pkg::CNT_W;
    localparam int DW = mts_pkg::DATA_WIDTH;

    localparam logic [CW-1:0] FULL_CNT = CW'(mts_pkg::DEPTH);

    // Stack storage. The minimum memory has a second read port so that a pop
    // of the current minimum finds the entry below it in the same cycle.
    logic signed [DW-1:0] value_mem [mts_pkg::DEPTH];
    logic signed [DW-1:0] min_mem   [mts_pkg::DEPTH];

    mts_pkg::state_t state_reg, state_next;

    logic [CW-1:0]         value_cnt_reg, value_cnt_next;
    logic [CW-1:0]         min_cnt_reg, min_cnt_next;
    mts_pkg::req_t         op_reg;
    logic signed [DW-1:0]  rd_top_reg;
    logic signed [DW-1:0]  rd_min_reg;
    logic signed [DW-1:0]  rd_min2_reg;
    logic                  out_valid_reg, out_valid_next;
    mts_pkg::rsp_t         out_data_reg, out_data_next;

    logic req_fire;
    logic exec_done;
    logic value_wr, min_wr;

    logic is_empty, is_full;
    logic push_min, pop_min;

    assign req_fire  = req.valid && req.ready;
    assign exec_done = (state_reg == mts_pkg::ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign is_empty = (value_cnt_reg == '0);
    assign is_full  = (value_cnt_reg == FULL_CNT);

    // A push joins the minimum stack when nothing is held or it is at most the
    // stored minimum; a pop of a value equal to the stored minimum leaves it.
    assign push_min = is_empty || (min_cnt_reg == '0) || (op_reg.value <= rd_min_reg);
    assign pop_min  = (min_cnt_reg != '0) && (rd_top_reg == rd_min_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = mts_pkg::ST_EXEC;
                end
            end
            mts_pkg::ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = mts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == mts_pkg::ST_IDLE);

    // Execute step: new counts, write enables and the result.
    always_comb
    begin
        value_cnt_next = value_cnt_reg;
        min_cnt_next   = min_cnt_reg;
        value_wr       = 1'b0;
        min_wr         = 1'b0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (exec_done)
        begin
            out_valid_next           = 1'b1;
            out_data_next.error_code = mts_pkg::ERR_NONE;
            case (op_reg.opcode)
                mts_pkg::OP_PUSH:
                begin
                    if (is_full)
                    begin
                        out_data_next.error_code   = mts_pkg::ERR_PUSH_FULL;
                        out_data_next.result_value = rd_top_reg;
                        out_data_next.min_value    = (min_cnt_reg != '0) ? rd_min_reg : '0;
                        out_data_next.is_empty     = 1'b0;
                        out_data_next.is_full      = 1'b1;
                    end
                    else
                    begin
                        value_wr       = 1'b1;
                        value_cnt_next = value_cnt_reg + 1'b1;
                        if (push_min)
                        begin
                            min_wr       = 1'b1;
                            min_cnt_next = min_cnt_reg + 1'b1;
                        end
                        out_data_next.result_value = op_reg.value;
                        out_data_next.min_value    = push_min ? op_reg.value : rd_min_reg;
                        out_data_next.is_empty     = 1'b0;
                        out_data_next.is_full      = (value_cnt_next == FULL_CNT);
                    end
                end
                mts_pkg::OP_POP:
                begin
                    if (is_empty)
                    begin
                        out_data_next.error_code   = mts_pkg::ERR_POP_EMPTY;
                        out_data_next.result_value = '0;
                        out_data_next.min_value    = '0;
                        out_data_next.is_empty     = 1'b1;
                        out_data_next.is_full      = 1'b0;
                    end
                    else
                    begin
                        value_cnt_next = value_cnt_reg - 1'b1;
                        if (value_cnt_next == '0)
                        begin
                            min_cnt_next = '0;
                        end
                        else if (pop_min)
                        begin
                            min_cnt_next = min_cnt_reg - 1'b1;
                        end
                        out_data_next.result_value = rd_top_reg;
                        if (min_cnt_next == '0)
                        begin
                            out_data_next.min_value = '0;
                        end
                        else
                        begin
                            out_data_next.min_value = pop_min ? rd_min2_reg : rd_min_reg;
                        end
                        out_data_next.is_empty = (value_cnt_next == '0);
                        out_data_next.is_full  = 1'b0;
                    end
                end
                default:
                begin
                    out_data_next.result_value = is_empty ? '0 : rd_top_reg;
                    out_data_next.min_value    =
                        (is_empty || min_cnt_reg == '0) ? '0 : rd_min_reg;
                    out_data_next.is_empty     = is_empty;
                    out_data_next.is_full      = is_full;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mts_pkg::ST_IDLE;
            value_cnt_reg <= '0;
            min_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            value_cnt_reg <= value_cnt_next;
            min_cnt_reg   <= min_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (req_fire)
        begin
            op_reg <= req.data;
        end
    end

    // Memory reads at the top of both stacks, issued when a request is taken.
    // Counts only change in the execute cycle, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rd_top_reg  <= value_mem[AW'(value_cnt_reg - 1'b1)];
            rd_min_reg  <= min_mem[AW'(min_cnt_reg - 1'b1)];
            rd_min2_reg <= min_mem[AW'(min_cnt_reg - 2'd2)];
        end
    end

    // Memory writes.
    always_ff @(posedge clk)
    begin
        if (value_wr)
        begin
            value_mem[AW'(value_cnt_reg)] <= op_reg.value;
        end
        if (min_wr)
        begin
            min_mem[AW'(min_cnt_reg)] <= op_reg.value;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

// ===== verif/min_tracking_stack_tb.sv =====
module min_tracking_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    // Number of random requests after the directed opening.
    localparam int RANDOM_REQUESTS = 1900;

    // Result counts after which the result side stops taking results for a
    // long stretch, so that the block backs up and stalls the request side.
    localparam int HOLD_AFTER_A = 300;
    localparam int HOLD_AFTER_B = 1300;
    localparam int HOLD_CYCLES  = 400;

    // Sign extremes that the value picker likes to use.
    localparam logic signed [DATA_WIDTH-1:0] MAX_VALUE = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // The scoreboard keeps its own copy of both stacks. Every accepted
    // request is run through that copy at once, and the result it should
    // produce is queued; results from the block are checked in order
    // against that queue.
    class stack_scoreboard;
        logic signed [DATA_WIDTH-1:0] value_stack [DEPTH];
        logic signed [DATA_WIDTH-1:0] min_stack [DEPTH];
        int unsigned                  depth_used;
        int unsigned                  min_used;
        rsp_t                         pending_results [$];
        int unsigned                  mismatches;

        function new();
            depth_used = 0;
            min_used   = 0;
            mismatches = 0;
        endfunction

        function logic signed [DATA_WIDTH-1:0] top_entry();
            return (depth_used == 0) ? '0 : value_stack[depth_used-1];
        endfunction

        function logic signed [DATA_WIDTH-1:0] min_entry();
            return (depth_used == 0 || min_used == 0) ? '0 : min_stack[min_used-1];
        endfunction

        function void note_request(req_t r);
            rsp_t                         exp;
            logic signed [DATA_WIDTH-1:0] popped;
            exp = '0;
            case (r.opcode)
                OP_PUSH:
                begin
                    if (depth_used >= DEPTH)
                    begin
                        exp.error_code   = ERR_PUSH_FULL;
                        exp.result_value = top_entry();
                    end
                    else
                    begin
                        // Ties go onto the minimum stack too, so that popping
                        // one copy of the minimum leaves the other in place.
                        if (depth_used == 0 || min_used == 0 ||
                            $signed(r.value) <= $signed(min_stack[min_used-1]))
                        begin
                            if (min_used < DEPTH)
                            begin
                                min_stack[min_used] = r.value;
                                min_used++;
                            end
                        end
                        value_stack[depth_used] = r.value;
                        depth_used++;
                        exp.result_value = r.value;
                    end
                end
                OP_POP:
                begin
                    if (depth_used == 0)
                    begin
                        exp.error_code = ERR_POP_EMPTY;
                    end
                    else
                    begin
                        popped = value_stack[depth_used-1];
                        depth_used--;
                        if (min_used > 0 && popped == min_stack[min_used-1])
                        begin
                            min_used--;
                        end
                        if (depth_used == 0)
                        begin
                            min_used = 0;
                        end
                        exp.result_value = popped;
                    end
                end
                default:
                begin
                    exp.result_value = top_entry();
                end
            endcase
            exp.min_value = min_entry();
            exp.is_empty  = (depth_used == 0);
            exp.is_full   = (depth_used >= DEPTH);
            pending_results.push_back(exp);
        endfunction

        function void report(string field, longint expv, longint gotv);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, gotv);
            mismatches++;
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, actual %p", $time, got);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.result_value !== exp.result_value)
                report("result_value", exp.result_value, got.result_value);
            if (got.min_value !== exp.min_value)
                report("min_value", exp.min_value, got.min_value);
            if (got.is_empty !== exp.is_empty)
                report("is_empty", exp.is_empty, got.is_empty);
            if (got.is_full !== exp.is_full)
                report("is_full", exp.is_full, got.is_full);
            if (got.error_code !== exp.error_code)
                report("error_code", exp.error_code, got.error_code);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mts_req_if req_ch ();
    mts_rsp_if rsp_ch ();

    stack_scoreboard sb;

    // When set, the request side offers back to back with no idle cycles.
    bit no_gaps;

    min_tracking_stack dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // Offers one request and returns at the edge where it is taken. Valid is
    // lowered only when an idle gap follows, so a back-to-back request never
    // sees valid dropped and raised within one time step.
    task automatic send_request(input logic [1:0] op, input logic signed [DATA_WIDTH-1:0] v);
        int   gap;
        req_t r;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        r.opcode = op;
        r.value  = v;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        // Ready is read in the active region of the edge, so it is the value
        // that the block itself sampled there.
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    // Values lean toward a narrow band around zero so that ties with the
    // current minimum are frequent; the rest are full-range or extremes.
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return int'($urandom_range(0, 16)) - 8;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return MAX_VALUE;
                    1: return MIN_VALUE;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Result side: draws a stall before each result, has calm stretches with
    // ready held high, and twice holds off for a long time while the request
    // side keeps offering.
    initial
    begin : result_sink
        int gap;
        int seen;
        int calm;
        seen = 0;
        calm = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (seen == HOLD_AFTER_A || seen == HOLD_AFTER_B)
            begin
                gap = HOLD_CYCLES;
            end
            else if (calm > 0)
            begin
                gap = 0;
                calm--;
            end
            else
            begin
                gap = $urandom_range(0, 12);
                if ($urandom_range(0, 9) == 0)
                    calm = $urandom_range(20, 60);
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            sb.check_result(rsp_ch.data);
            seen++;
        end
    end

    // Stimulus: a directed opening, then random segments that each lean
    // toward pushing, popping or a mix, so the stack swings between full and
    // empty many times and both error cases come up repeatedly.
    initial
    begin : request_source
        int sent;
        int seg_len;
        int push_pct;
        int pick;
        logic [1:0] op;

        sb = new();
        no_gaps      = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Query, pop and the unused opcode on an empty stack.
        send_request(OP_QUERY, '0);
        send_request(OP_POP, $urandom);
        send_request(OP_RSVD, $urandom);
        // Sign extremes and a duplicated minimum.
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, MAX_VALUE);
        send_request(OP_PUSH, MIN_VALUE);
        send_request(OP_PUSH, MIN_VALUE);
        send_request(OP_PUSH, '1);
        send_request(OP_PUSH, 32'h5555_5555);
        send_request(OP_PUSH, 32'haaaa_aaaa);
        send_request(OP_QUERY, $urandom);
        send_request(OP_RSVD, $urandom);
        // Unwind: one copy of the minimum goes, the other keeps it in place.
        repeat (7) send_request(OP_POP, $urandom);
        send_request(OP_POP, $urandom);
        // A smaller value pushed twice above a larger one on an empty stack.
        send_request(OP_PUSH, 5);
        send_request(OP_PUSH, 3);
        send_request(OP_PUSH, 3);
        repeat (3) send_request(OP_POP, $urandom);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            seg_len = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 48;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len && sent < RANDOM_REQUESTS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct)
                    op = OP_PUSH;
                else if (pick < 95)
                    op = OP_POP;
                else if (pick < 98)
                    op = OP_QUERY;
                else
                    op = OP_RSVD;
                send_request(op, pick_value());
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain every outstanding result, then keep watching for a stray one.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mts_pkg.sv
hw/rtl/mts_req_if.sv
hw/rtl/mts_rsp_if.sv
hw/rtl/min_tracking_stack.sv
verif/min_tracking_stack_tb.sv
